### rtl/chs_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
`timescale 1ns / 1ps
`default_nettype none

package chs_pkg;

  // The angle accumulator counts in 1/65536 degree.
  localparam int ZW = 26;
  localparam int GUARD_BITS = 8;
  localparam int HEADING_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int ROUND_SHIFT = 9;
  localparam int TABLE_IDX_BITS = 5;

  localparam logic signed [ZW-1:0] DEG90_Z = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180_Z = 26'sd11796480;
  localparam logic signed [ZW-1:0] ROUND_HALF = 26'sd256;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1
  } cfg_reg_t;

  // Side information that travels alongside each request through the cells.
  typedef struct packed {
    logic neg_x;
    logic zero;
  } flags_t;

  // atan(2^-i) in degrees, scaled by 65536 and rounded.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [TABLE_IDX_BITS-1:0] idx);
    logic signed [ZW-1:0] t;
    case (idx)
      5'd0:    t = 26'sd2949120;
      5'd1:    t = 26'sd1740967;
      5'd2:    t = 26'sd919879;
      5'd3:    t = 26'sd466945;
      5'd4:    t = 26'sd234379;
      5'd5:    t = 26'sd117304;
      5'd6:    t = 26'sd58666;
      5'd7:    t = 26'sd29335;
      5'd8:    t = 26'sd14668;
      5'd9:    t = 26'sd7334;
      5'd10:   t = 26'sd3667;
      5'd11:   t = 26'sd1833;
      5'd12:   t = 26'sd917;
      5'd13:   t = 26'sd458;
      5'd14:   t = 26'sd229;
      5'd15:   t = 26'sd115;
      5'd16:   t = 26'sd57;
      5'd17:   t = 26'sd29;
      5'd18:   t = 26'sd14;
      5'd19:   t = 26'sd7;
      5'd20:   t = 26'sd4;
      5'd21:   t = 26'sd2;
      5'd22:   t = 26'sd1;
      default: t = 26'sd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/compass_heading_from_magnetometer.sv
// Top level: offset registers, front end, a chain of CORDIC cells and the output stage.
// A request moves through the front register, the CORDIC cells and the output register in turn.
// Throughput: one request per cycle while in_stall is low; the unrolled CORDIC chain sets this.
// A stalled output fills a one-entry skid stage, after which in_stall rises and the chain holds.
// Reset clears the offsets to zero and empties every stage; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_from_magnetometer #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]           mag_x,
  input  wire logic signed [SAMPLE_BITS-1:0]           mag_y,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [chs_pkg::HEADING_BITS-1:0]      heading,
  output logic                                         zero_vector,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [chs_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  wire logic [chs_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

  // Room for the guard bits, the CORDIC gain and the sign.
  localparam int W = SAMPLE_BITS + 11;

  logic signed [SAMPLE_BITS-1:0] offset_x;
  logic signed [SAMPLE_BITS-1:0] offset_y;
  logic                          en;

  logic                          c_valid [0:CORDIC_STAGES];
  logic signed [W-1:0]           c_u     [0:CORDIC_STAGES];
  logic signed [W-1:0]           c_v     [0:CORDIC_STAGES];
  logic signed [chs_pkg::ZW-1:0] c_z     [0:CORDIC_STAGES];
  chs_pkg::flags_t               c_flags [0:CORDIC_STAGES];

  assign cfg_ready = 1'b1;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (chs_pkg::cfg_reg_t'(cfg_index))
        chs_pkg::REG_OFFSET_X: offset_x <= SAMPLE_BITS'(cfg_data);
        chs_pkg::REG_OFFSET_Y: offset_y <= SAMPLE_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  chs_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .W(W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .mag_x(mag_x),
    .mag_y(mag_y),
    .offset_x(offset_x),
    .offset_y(offset_y),
    .valid(c_valid[0]),
    .u(c_u[0]),
    .v(c_v[0]),
    .z(c_z[0]),
    .flags(c_flags[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    chs_cell #(
      .IDX(i),
      .W(W)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .in_valid(c_valid[i]),
      .in_u(c_u[i]),
      .in_v(c_v[i]),
      .in_z(c_z[i]),
      .in_flags(c_flags[i]),
      .valid(c_valid[i+1]),
      .u(c_u[i+1]),
      .v(c_v[i+1]),
      .z(c_z[i+1]),
      .flags(c_flags[i+1])
    );
  end

  chs_out u_out (
    .clk(clk),
    .rst(rst),
    .in_valid(c_valid[CORDIC_STAGES]),
    .in_z(c_z[CORDIC_STAGES]),
    .in_flags(c_flags[CORDIC_STAGES]),
    .en(en),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .heading(heading),
    .zero_vector(zero_vector)
  );

endmodule

`default_nettype wire

### rtl/chs_front.sv
// Offset correction, absolute value of x and quadrant pre-rotation ahead of the CORDIC cells.
`timescale 1ns / 1ps
`default_nettype none

module chs_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int W = 27
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [SAMPLE_BITS-1:0]  mag_x,
  input  wire logic signed [SAMPLE_BITS-1:0]  mag_y,
  input  wire logic signed [SAMPLE_BITS-1:0]  offset_x,
  input  wire logic signed [SAMPLE_BITS-1:0]  offset_y,
  output logic                                valid,
  output logic signed [W-1:0]                 u,
  output logic signed [W-1:0]                 v,
  output logic signed [chs_pkg::ZW-1:0]       z,
  output chs_pkg::flags_t                     flags
);

  logic signed [SAMPLE_BITS:0] cx;
  logic signed [SAMPLE_BITS:0] cy;
  logic signed [W-1:0]         cx_w;
  logic signed [W-1:0]         cy_w;
  logic signed [W-1:0]         ax_w;
  logic signed [W-1:0]         u0;
  logic signed [W-1:0]         v0;
  logic signed [W-1:0]         u_next;
  logic signed [W-1:0]         v_next;
  logic signed [chs_pkg::ZW-1:0] z_next;
  chs_pkg::flags_t             flags_next;

  always_comb begin
    cx = {mag_x[SAMPLE_BITS-1], mag_x} - {offset_x[SAMPLE_BITS-1], offset_x};
    cy = {mag_y[SAMPLE_BITS-1], mag_y} - {offset_y[SAMPLE_BITS-1], offset_y};
    cx_w = {{(W-SAMPLE_BITS-1){cx[SAMPLE_BITS]}}, cx};
    cy_w = {{(W-SAMPLE_BITS-1){cy[SAMPLE_BITS]}}, cy};
    ax_w = cx[SAMPLE_BITS] ? -cx_w : cx_w;
    u0 = cy_w <<< chs_pkg::GUARD_BITS;
    v0 = ax_w <<< chs_pkg::GUARD_BITS;
    // A vector in the southern half is turned by -90 degrees first.
    if (cy[SAMPLE_BITS]) begin
      u_next = v0;
      v_next = -u0;
      z_next = chs_pkg::DEG90_Z;
    end else begin
      u_next = u0;
      v_next = v0;
      z_next = '0;
    end
    flags_next.neg_x = cx[SAMPLE_BITS];
    flags_next.zero = (cx == '0) && (cy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u <= u_next;
      v <= v_next;
      z <= z_next;
      flags <= flags_next;
    end
  end

endmodule

`default_nettype wire

### rtl/chs_cell.sv
// One CORDIC vectoring cell: a fixed shift, two add/subtracts and an angle step.
`timescale 1ns / 1ps
`default_nettype none

module chs_cell #(
  parameter int IDX = 0,
  parameter int W = 27
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [W-1:0]            in_u,
  input  wire logic signed [W-1:0]            in_v,
  input  wire logic signed [chs_pkg::ZW-1:0]  in_z,
  input  wire chs_pkg::flags_t                in_flags,
  output logic                                valid,
  output logic signed [W-1:0]                 u,
  output logic signed [W-1:0]                 v,
  output logic signed [chs_pkg::ZW-1:0]       z,
  output chs_pkg::flags_t                     flags
);

  localparam logic signed [chs_pkg::ZW-1:0] STEP =
    chs_pkg::atan_entry(chs_pkg::TABLE_IDX_BITS'(IDX));

  logic signed [W-1:0]           du;
  logic signed [W-1:0]           dv;
  logic signed [W-1:0]           u_next;
  logic signed [W-1:0]           v_next;
  logic signed [chs_pkg::ZW-1:0] z_next;

  always_comb begin
    du = in_v >>> IDX;
    dv = in_u >>> IDX;
    // Rotate towards the u axis; the sign of v picks the direction.
    if (!in_v[W-1]) begin
      u_next = in_u + du;
      v_next = in_v - dv;
      z_next = in_z + STEP;
    end else begin
      u_next = in_u - du;
      v_next = in_v + dv;
      z_next = in_z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u <= u_next;
      v <= v_next;
      z <= z_next;
      flags <= in_flags;
    end
  end

endmodule

`default_nettype wire

### rtl/chs_out.sv
// Angle clamp and rounding, then the output register with a skid stage behind it.
`timescale 1ns / 1ps
`default_nettype none

module chs_out (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  input  wire logic signed [chs_pkg::ZW-1:0]          in_z,
  input  wire chs_pkg::flags_t                        in_flags,
  output logic                                        en,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [chs_pkg::HEADING_BITS-1:0]     heading,
  output logic                                        zero_vector
);

  logic signed [chs_pkg::ZW-1:0]           z_clamp;
  logic signed [chs_pkg::ZW-1:0]           z_round;
  logic signed [chs_pkg::HEADING_BITS-1:0] mag;
  logic signed [chs_pkg::HEADING_BITS-1:0] head_next;
  logic                                    skid_valid;
  logic signed [chs_pkg::HEADING_BITS-1:0] skid_heading;
  logic                                    skid_zero;

  always_comb begin
    if (in_z < 0) begin
      z_clamp = '0;
    end else if (in_z > chs_pkg::DEG180_Z) begin
      z_clamp = chs_pkg::DEG180_Z;
    end else begin
      z_clamp = in_z;
    end
    z_round = (z_clamp + chs_pkg::ROUND_HALF) >>> chs_pkg::ROUND_SHIFT;
    mag = z_round[chs_pkg::HEADING_BITS-1:0];
    if (in_flags.zero) begin
      head_next = '0;
    end else if (in_flags.neg_x) begin
      head_next = -mag;
    end else begin
      head_next = mag;
    end
  end

  // The cells move only while the skid stage is empty.
  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        heading <= skid_heading;
        zero_vector <= skid_zero;
      end else begin
        heading <= head_next;
        zero_vector <= in_flags.zero;
      end
    end else if (!skid_valid) begin
      skid_heading <= head_next;
      skid_zero <= in_flags.zero;
    end
  end

endmodule

`default_nettype wire
